// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset
`define ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette fader: same-cycle check failed");

// Next-cycle implication, quiet during reset
`define ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette fader: next-cycle check failed");

`endif

// File: hw/rtl/pif_pkg.sv
`default_nettype none
package pif_pkg;

	// Palette size and entry index width
	localparam int NUM_ENTRIES = 16;
	localparam int ENT_W = $clog2(NUM_ENTRIES);
	localparam logic [4:0] NUM_ENT_V = 5'(NUM_ENTRIES);

	// Command codes
	localparam logic [2:0] CMD_SET_RGB = 3'd0;
	localparam logic [2:0] CMD_SET_LVL = 3'd1;
	localparam logic [2:0] CMD_SET_ALL = 3'd2;
	localparam logic [2:0] CMD_FADE_OUT = 3'd3;
	localparam logic [2:0] CMD_FADE_IN = 3'd4;
	localparam logic [2:0] CMD_READ = 3'd5;
	localparam logic [2:0] CMD_BLEND = 3'd6;

	// Channel codes
	localparam logic [1:0] CH_R = 2'd0;
	localparam logic [1:0] CH_G = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;

	localparam logic [6:0] FULL_LEVEL = 7'd100;
	localparam logic [5:0] CHAN_MAX = 6'd63;

	// Reciprocals for x/100 (x <= 6300) and x/3 (x <= 189)
	localparam logic [12:0] RECIP100 = 13'd5243;
	localparam int SHIFT100 = 19;
	localparam logic [12:0] RECIP3 = 13'd171;
	localparam int SHIFT3 = 9;

	typedef struct packed {
		logic [5:0] b;
		logic [5:0] g;
		logic [5:0] r;
	} rgb_t;

	// Request into the shared scale unit: q = (a*b + c) / (div3 ? 3 : 100)
	typedef struct packed {
		logic vld;
		logic div3;
		logic [5:0] a;
		logic [6:0] b;
		logic [5:0] c;
		logic [ENT_W-1:0] ent;
		logic [1:0] ch;
	} su_req_t;

	typedef struct packed {
		logic vld;
		logic busy;
		logic div3;
		logic [5:0] q;
		logic [ENT_W-1:0] ent;
		logic [1:0] ch;
	} su_rsp_t;

	// Standard sixteen-color default table
	function automatic rgb_t default_rgb(input logic [3:0] idx);
		rgb_t c;
		c = '0;
		unique case (idx)
			4'd0: c = '{b: 6'd0, g: 6'd0, r: 6'd0};
			4'd1: c = '{b: 6'd42, g: 6'd0, r: 6'd0};
			4'd2: c = '{b: 6'd0, g: 6'd42, r: 6'd0};
			4'd3: c = '{b: 6'd42, g: 6'd42, r: 6'd0};
			4'd4: c = '{b: 6'd0, g: 6'd0, r: 6'd42};
			4'd5: c = '{b: 6'd42, g: 6'd0, r: 6'd42};
			4'd6: c = '{b: 6'd0, g: 6'd21, r: 6'd42};
			4'd7: c = '{b: 6'd42, g: 6'd42, r: 6'd42};
			4'd8: c = '{b: 6'd21, g: 6'd21, r: 6'd21};
			4'd9: c = '{b: 6'd63, g: 6'd21, r: 6'd21};
			4'd10: c = '{b: 6'd21, g: 6'd63, r: 6'd21};
			4'd11: c = '{b: 6'd63, g: 6'd63, r: 6'd21};
			4'd12: c = '{b: 6'd21, g: 6'd21, r: 6'd63};
			4'd13: c = '{b: 6'd63, g: 6'd21, r: 6'd63};
			4'd14: c = '{b: 6'd21, g: 6'd63, r: 6'd63};
			4'd15: c = '{b: 6'd63, g: 6'd63, r: 6'd63};
		endcase
		return c;
	endfunction

	function automatic logic [5:0] clamp_chan(input logic signed [7:0] v);
		logic [5:0] r;
		priority if (v[7])
			r = '0;
		else if (v[6])
			r = CHAN_MAX;
		else
			r = v[5:0];
		return r;
	endfunction

	function automatic logic [6:0] clamp_level(input logic signed [7:0] v);
		logic [6:0] r;
		priority if (v[7])
			r = '0;
		else if (v[6:0] > FULL_LEVEL)
			r = FULL_LEVEL;
		else
			r = v[6:0];
		return r;
	endfunction

	function automatic logic [5:0] chan_sel(input rgb_t c, input logic [1:0] ch);
		logic [5:0] r;
		r = '0;
		case (ch)
			CH_R: r = c.r;
			CH_G: r = c.g;
			CH_B: r = c.b;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pif_scale_unit.sv
`default_nettype none
module pif_scale_unit
	import pif_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire su_req_t req,
	output su_rsp_t rsp
);

	logic vld_s1;
	logic div3_s1;
	logic [12:0] prod_s1;
	logic [ENT_W-1:0] ent_s1;
	logic [1:0] ch_s1;

	logic vld_s2;
	logic div3_s2;
	logic [5:0] q_s2;
	logic [ENT_W-1:0] ent_s2;
	logic [1:0] ch_s2;

	logic [25:0] recip_prod;

	// Stage 1: multiply-add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (req.vld) begin
			prod_s1 <= 13'(req.a) * 13'(req.b) + 13'(req.c);
			div3_s1 <= req.div3;
			ent_s1 <= req.ent;
			ch_s1 <= req.ch;
		end
	end

	// Stage 2: divide by constant through a reciprocal
	assign recip_prod = 26'(prod_s1) * 26'(div3_s1 ? RECIP3 : RECIP100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			q_s2 <= div3_s1 ? recip_prod[SHIFT3 +: 6] : recip_prod[SHIFT100 +: 6];
			div3_s2 <= div3_s1;
			ent_s2 <= ent_s1;
			ch_s2 <= ch_s1;
		end
	end

	assign rsp.vld = vld_s2;
	assign rsp.busy = vld_s1 | vld_s2;
	assign rsp.div3 = div3_s2;
	assign rsp.q = q_s2;
	assign rsp.ent = ent_s2;
	assign rsp.ch = ch_s2;

endmodule
`default_nettype wire

// File: hw/rtl/palette_intensity_fader.sv
// Palette intensity fader: a 16-entry palette of 6-bit RGB colors, each with
// a percent intensity, a saved intensity and a shown (scaled) copy.
// Input stream: s_axis_tuser carries the command, s_axis_tdata its operands.
// Output stream: exactly one result beat per command, reporting the entry
// after the command has acted (or the blended color for a blend read).
// Flow: every command passes through an update step. Set all / fade out /
// fade in then rescale every entry, and set rgb / set intensity the one
// valid entry, through one shared multiply/divide-by-constant unit, one color
// channel per cycle; a blend read holds the weak color, then blends through
// the same unit, and a read (or invalid index) goes straight to its result.
// The shared unit sets the rate; s_axis_tready is high only while the
// sequencer is idle, so a new command waits until the previous one finishes.
// A finished result sits in the output register; the next command may start
// while it waits, and its result is held back until the register is taken.
// Reset (arst_n low) loads the default colors, all intensities to 100 and
// clears the faded flag and the result valid at once; no clearing pass.
// s_axis_tready is high from reset on.
`default_nettype none
`include "assert_macros.svh"
module palette_intensity_fader
	import pif_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: color_index[3:0], red_in[11:4], green_in[19:12], blue_in[27:20],
	//        level[35:28], blend_index[43:36], zero pad[47:44]
	input wire logic [47:0] s_axis_tdata,
	// tuser: cmd[2:0]
	input wire logic [2:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// tdata: base_red[5:0], base_green[11:6], base_blue[17:12],
	//        entry_intensity[24:18], shown_red[30:25], shown_green[36:31],
	//        shown_blue[42:37], fade_flag[43], zero pad[47:44]
	output logic [47:0] m_axis_tdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD = 3'd1;
	localparam logic [2:0] ST_HOLD = 3'd2;
	localparam logic [2:0] ST_ISSUE = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	localparam logic [ENT_W-1:0] LAST_ENT = ENT_W'(NUM_ENTRIES - 1);

	logic [2:0] state_q;
	logic faded_q;
	logic [ENT_W-1:0] ent_q;
	logic [ENT_W-1:0] last_ent_q;
	logic [1:0] ch_q;

	// Captured command
	logic [2:0] cmd_q;
	logic [3:0] cidx_q;
	rgb_t rgb_in_q;
	logic [6:0] pct_q;
	logic [7:0] blend_idx_q;

	// Palette storage
	rgb_t base_q [NUM_ENTRIES];
	rgb_t shown_q [NUM_ENTRIES];
	logic [6:0] int_q [NUM_ENTRIES];
	logic [6:0] saved_q [NUM_ENTRIES];

	rgb_t hold_q;
	rgb_t blend_q;
	logic m_tvalid_q;
	logic [47:0] m_tdata_q;

	logic accept;
	logic idx_valid;
	logic [ENT_W-1:0] idx;
	logic is_single;
	logic is_bcast;
	logic is_blend;
	logic [ENT_W-1:0] rd_ent;
	logic [3:0] sh_nib;
	rgb_t shown_rd;
	rgb_t base_rd;
	logic [6:0] level_rd;
	logic out_free;
	logic [43:0] res;
	su_req_t su_req;
	su_rsp_t su_rsp;

	assign accept = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign idx = cidx_q[ENT_W-1:0];
	assign idx_valid = (5'(cidx_q) < NUM_ENT_V);
	assign is_single = (cmd_q == CMD_SET_RGB) || (cmd_q == CMD_SET_LVL);
	assign is_bcast = (cmd_q == CMD_SET_ALL) || (cmd_q == CMD_FADE_OUT) ||
		(cmd_q == CMD_FADE_IN);
	assign is_blend = (cmd_q == CMD_BLEND);
	assign out_free = !m_tvalid_q || m_axis_tready;

	// Capture the command operands
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_axis_tuser;
			cidx_q <= s_axis_tdata[3:0];
			rgb_in_q.r <= clamp_chan(s_axis_tdata[11:4]);
			rgb_in_q.g <= clamp_chan(s_axis_tdata[19:12]);
			rgb_in_q.b <= clamp_chan(s_axis_tdata[27:20]);
			pct_q <= clamp_level(s_axis_tdata[35:28]);
			blend_idx_q <= s_axis_tdata[43:36];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q <= '0;
			last_ent_q <= '0;
			ch_q <= CH_R;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					ch_q <= CH_R;
					ent_q <= is_single ? idx : '0;
					last_ent_q <= is_single ? idx : LAST_ENT;
					priority if ((is_single && idx_valid) || is_bcast)
						state_q <= ST_ISSUE;
					else if (is_blend)
						state_q <= ST_HOLD;
					else
						state_q <= ST_RESP;
				end
				ST_HOLD: begin
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					if (ch_q == CH_B) begin
						ch_q <= CH_R;
						if (is_blend || ent_q == last_ent_q)
							state_q <= ST_DRAIN;
						else
							ent_q <= ent_q + 1'b1;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!su_rsp.busy)
						state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Faded flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faded_q <= 1'b0;
		end else if (state_q == ST_UPD) begin
			if (cmd_q == CMD_FADE_OUT)
				faded_q <= 1'b1;
			else if (cmd_q == CMD_FADE_IN)
				faded_q <= 1'b0;
		end
	end

	// Base colors: written by set rgb
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NUM_ENTRIES; e++)
				base_q[e] <= default_rgb(4'(e));
		end else if (state_q == ST_UPD && cmd_q == CMD_SET_RGB && idx_valid) begin
			base_q[idx] <= rgb_in_q;
		end
	end

	// Intensities and saved levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NUM_ENTRIES; e++) begin
				int_q[e] <= FULL_LEVEL;
				saved_q[e] <= FULL_LEVEL;
			end
		end else if (state_q == ST_UPD) begin
			for (int e = 0; e < NUM_ENTRIES; e++) begin
				if (cmd_q == CMD_SET_ALL ||
						(cmd_q == CMD_SET_LVL && idx_valid && idx == ENT_W'(e))) begin
					if (faded_q)
						saved_q[e] <= pct_q;
					else
						int_q[e] <= pct_q;
				end else if (cmd_q == CMD_FADE_OUT && !faded_q) begin
					saved_q[e] <= int_q[e];
					int_q[e] <= '0;
				end else if (cmd_q == CMD_FADE_IN && faded_q) begin
					int_q[e] <= saved_q[e];
				end
			end
		end
	end

	// One read address, chosen by the step, for the base colors and reported level
	assign rd_ent = (state_q == ST_RESP) ? idx : ent_q;
	assign base_rd = base_q[rd_ent];
	assign level_rd = faded_q ? saved_q[rd_ent] : int_q[rd_ent];

	always_comb begin
		case (state_q)
			ST_HOLD: sh_nib = blend_idx_q[7:4];
			ST_ISSUE: sh_nib = blend_idx_q[3:0];
			default: sh_nib = cidx_q;
		endcase
	end

	assign shown_rd = (5'(sh_nib) < NUM_ENT_V) ? shown_q[sh_nib[ENT_W-1:0]] : '0;

	// Hold the weak blend color
	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD)
			hold_q <= shown_rd;
	end

	// Issue one channel per cycle to the shared unit
	always_comb begin
		su_req.vld = (state_q == ST_ISSUE);
		su_req.div3 = is_blend;
		su_req.ent = ent_q;
		su_req.ch = ch_q;
		if (is_blend) begin
			su_req.a = chan_sel(shown_rd, ch_q);
			su_req.b = 7'd2;
			su_req.c = chan_sel(hold_q, ch_q);
		end else begin
			su_req.a = chan_sel(base_rd, ch_q);
			su_req.b = int_q[ent_q];
			su_req.c = '0;
		end
	end

	pif_scale_unit u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.req(su_req),
		.rsp(su_rsp)
	);

	// Write back scaled channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NUM_ENTRIES; e++)
				shown_q[e] <= default_rgb(4'(e));
		end else if (su_rsp.vld && !su_rsp.div3) begin
			case (su_rsp.ch)
				CH_R: shown_q[su_rsp.ent].r <= su_rsp.q;
				CH_G: shown_q[su_rsp.ent].g <= su_rsp.q;
				CH_B: shown_q[su_rsp.ent].b <= su_rsp.q;
				default: ;
			endcase
		end
	end

	// Collect blended channels
	always_ff @(posedge clk) begin
		if (su_rsp.vld && su_rsp.div3) begin
			case (su_rsp.ch)
				CH_R: blend_q.r <= su_rsp.q;
				CH_G: blend_q.g <= su_rsp.q;
				CH_B: blend_q.b <= su_rsp.q;
				default: ;
			endcase
		end
	end

	// Assemble the result beat
	always_comb begin
		priority if (is_blend)
			res = {faded_q, blend_q.b, blend_q.g, blend_q.r, 7'd0, 18'd0};
		else if (idx_valid)
			res = {faded_q, shown_rd.b, shown_rd.g, shown_rd.r, level_rd,
				base_rd.b, base_rd.g, base_rd.r};
		else
			res = {faded_q, 43'd0};
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free)
			m_tdata_q <= {4'd0, res};
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;

	`ASSERT_NEXT(a_accept_update, s_axis_tvalid && s_axis_tready, state_q == ST_UPD)
	`ASSERT_NEXT(a_resp_loads, (state_q == ST_RESP) && out_free, m_axis_tvalid && (state_q == ST_IDLE))
	`ASSERT_IMPL(a_idle_unit_quiet, state_q == ST_IDLE, !su_rsp.busy)

endmodule
`default_nettype wire

// File: tb/palette_fade_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the palette fader: tracks the palette in step with every
// accepted command beat and checks each result beat against the oldest
// predicted entry report.
module palette_fade_checker
	import pif_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	// tdata: color_index[3:0], red_in[11:4], green_in[19:12], blue_in[27:20],
	//        level[35:28], blend_index[43:36], zero pad[47:44]
	input logic [47:0] s_axis_tdata,
	// tuser: cmd[2:0]
	input logic [2:0] s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata: base_red[5:0], base_green[11:6], base_blue[17:12],
	//        entry_intensity[24:18], shown_red[30:25], shown_green[36:31],
	//        shown_blue[42:37], fade_flag[43], zero pad[47:44]
	input logic [47:0] m_axis_tdata,
	output int errors,
	output int pending
);

	// Members listed from the top bit down so a cast of tdata[43:0] lines up
	typedef struct packed {
		logic faded;
		logic [5:0] shown_b;
		logic [5:0] shown_g;
		logic [5:0] shown_r;
		logic [6:0] level;
		logic [5:0] base_b;
		logic [5:0] base_g;
		logic [5:0] base_r;
	} entry_report_t;

	// Palette copy
	rgb_t base_q[16];
	rgb_t shown_q[16];
	logic [6:0] level_q[16];
	logic [6:0] saved_q[16];
	logic faded_q;

	entry_report_t pending_reports[$];
	entry_report_t got_report;
	entry_report_t want_report;

	// Power-on colors, packed as {b, g, r}
	function automatic rgb_t power_on_color(input int e);
		rgb_t c;
		c = '0;
		case (e)
			1: c = {6'd42, 6'd0, 6'd0};
			2: c = {6'd0, 6'd42, 6'd0};
			3: c = {6'd42, 6'd42, 6'd0};
			4: c = {6'd0, 6'd0, 6'd42};
			5: c = {6'd42, 6'd0, 6'd42};
			6: c = {6'd0, 6'd21, 6'd42};
			7: c = {6'd42, 6'd42, 6'd42};
			8: c = {6'd21, 6'd21, 6'd21};
			9: c = {6'd63, 6'd21, 6'd21};
			10: c = {6'd21, 6'd63, 6'd21};
			11: c = {6'd63, 6'd63, 6'd21};
			12: c = {6'd21, 6'd21, 6'd63};
			13: c = {6'd63, 6'd21, 6'd63};
			14: c = {6'd21, 6'd63, 6'd63};
			15: c = {6'd63, 6'd63, 6'd63};
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [5:0] sat_chan(input logic signed [7:0] v);
		if (v < 8'sd0)
			return 6'd0;
		if (v > 8'sd63)
			return 6'd63;
		return v[5:0];
	endfunction

	function automatic logic [6:0] sat_level(input logic signed [7:0] v);
		if (v < 8'sd0)
			return 7'd0;
		if (v > 8'sd100)
			return 7'd100;
		return v[6:0];
	endfunction

	// Truncating channel * percent / 100
	function automatic logic [5:0] scaled(input logic [5:0] c, input logic [6:0] p);
		int prod;
		prod = int'(c) * int'(p);
		return 6'(prod / 100);
	endfunction

	// Low nibble color weighted double, truncating divide by three
	function automatic logic [5:0] mixed(input logic [5:0] lo_c, input logic [5:0] hi_c);
		int sum;
		sum = 2 * int'(lo_c) + int'(hi_c);
		return 6'(sum / 3);
	endfunction

	function automatic void rescale_entry(input int e);
		shown_q[e].r = scaled(base_q[e].r, level_q[e]);
		shown_q[e].g = scaled(base_q[e].g, level_q[e]);
		shown_q[e].b = scaled(base_q[e].b, level_q[e]);
	endfunction

	// While faded only the saved level takes the write
	function automatic void put_level(input int e, input logic [6:0] p);
		if (faded_q) begin
			saved_q[e] = p;
		end else begin
			level_q[e] = p;
			rescale_entry(e);
		end
	endfunction

	function automatic rgb_t shown_or_black(input int e);
		if (e < NUM_ENTRIES)
			return shown_q[e];
		return '0;
	endfunction

	// Apply one command to the palette copy and build the report it returns
	function automatic entry_report_t apply_command(input logic [2:0] op,
			input logic [47:0] d);
		int idx;
		logic in_range;
		logic [6:0] pct;
		rgb_t lo_c;
		rgb_t hi_c;
		entry_report_t rep;
		idx = int'(d[3:0]);
		in_range = idx < NUM_ENTRIES;
		pct = sat_level(d[35:28]);
		case (op)
			CMD_SET_RGB: begin
				if (in_range) begin
					base_q[idx].r = sat_chan(d[11:4]);
					base_q[idx].g = sat_chan(d[19:12]);
					base_q[idx].b = sat_chan(d[27:20]);
					rescale_entry(idx);
				end
			end
			CMD_SET_LVL: begin
				if (in_range)
					put_level(idx, pct);
			end
			CMD_SET_ALL: begin
				for (int e = 0; e < NUM_ENTRIES; e++)
					put_level(e, pct);
			end
			CMD_FADE_OUT: begin
				if (!faded_q) begin
					for (int e = 0; e < NUM_ENTRIES; e++) begin
						saved_q[e] = level_q[e];
						level_q[e] = 7'd0;
						rescale_entry(e);
					end
					faded_q = 1'b1;
				end
			end
			CMD_FADE_IN: begin
				if (faded_q) begin
					faded_q = 1'b0;
					for (int e = 0; e < NUM_ENTRIES; e++) begin
						level_q[e] = saved_q[e];
						rescale_entry(e);
					end
				end
			end
			default: ;
		endcase

		rep = '0;
		if (op == CMD_BLEND) begin
			lo_c = shown_or_black(int'(d[39:36]));
			hi_c = shown_or_black(int'(d[43:40]));
			rep.shown_r = mixed(lo_c.r, hi_c.r);
			rep.shown_g = mixed(lo_c.g, hi_c.g);
			rep.shown_b = mixed(lo_c.b, hi_c.b);
		end else if (in_range) begin
			rep.base_r = base_q[idx].r;
			rep.base_g = base_q[idx].g;
			rep.base_b = base_q[idx].b;
			rep.level = faded_q ? saved_q[idx] : level_q[idx];
			rep.shown_r = shown_q[idx].r;
			rep.shown_g = shown_q[idx].g;
			rep.shown_b = shown_q[idx].b;
		end
		rep.faded = faded_q;
		return rep;
	endfunction

	task automatic match_field(input string tag, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s expected %0d actual %0d", $time, tag, want, got);
		end
	endtask

	// Check result beats first: a command beat on the same edge is never the one reported
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < 16; e++) begin
				base_q[e] = power_on_color(e);
				shown_q[e] = power_on_color(e);
				level_q[e] = FULL_LEVEL;
				saved_q[e] = FULL_LEVEL;
			end
			faded_q = 1'b0;
			pending_reports.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_report = entry_report_t'(m_axis_tdata[43:0]);
				if (pending_reports.size() == 0) begin
					errors++;
					$display("%0t ns: result beat with nothing expected, actual %h",
						$time, m_axis_tdata);
				end else begin
					want_report = pending_reports.pop_front();
					match_field("base_red", want_report.base_r, got_report.base_r);
					match_field("base_green", want_report.base_g, got_report.base_g);
					match_field("base_blue", want_report.base_b, got_report.base_b);
					match_field("entry_intensity", want_report.level, got_report.level);
					match_field("shown_red", want_report.shown_r, got_report.shown_r);
					match_field("shown_green", want_report.shown_g, got_report.shown_g);
					match_field("shown_blue", want_report.shown_b, got_report.shown_b);
					match_field("fade_flag", want_report.faded, got_report.faded);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_reports.push_back(apply_command(s_axis_tuser, s_axis_tdata));
		end
		pending = pending_reports.size();
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top
	import pif_pkg::*;
();

	// Command code left unused by the block; it reports like a read
	localparam logic [2:0] CMD_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// tdata: color_index[3:0], red_in[11:4], green_in[19:12], blue_in[27:20],
	//        level[35:28], blend_index[43:36], zero pad[47:44]
	logic [47:0] s_axis_tdata = '0;
	// tuser: cmd[2:0]
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// tdata: base_red[5:0], base_green[11:6], base_blue[17:12],
	//        entry_intensity[24:18], shown_red[30:25], shown_green[36:31],
	//        shown_blue[42:37], fade_flag[43], zero pad[47:44]
	logic [47:0] m_axis_tdata;

	int fail_count;
	int reports_due;
	int send_idle_pct = 7;
	int recv_idle_pct = 88;
	int cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	palette_intensity_fader i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	palette_fade_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(fail_count),
		.pending(reports_due)
	);

	// Stall the result side at the current rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Present one command beat, with random idle cycles ahead of it, and hold until taken
	task automatic send_cmd(input logic [2:0] op, input logic [3:0] idx,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
			input logic [7:0] lvl, input logic [7:0] blend);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0, blend, lvl, blue, green, red, idx};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	function automatic logic [7:0] rand_chan();
		if ($urandom_range(3) == 0)
			return 8'($urandom);
		return 8'($urandom_range(63));
	endfunction

	// Mostly writes and reads, with fades often enough to cross the faded state
	task automatic send_random();
		int pick;
		logic [2:0] op;
		logic [7:0] lvl;
		pick = $urandom_range(99);
		if (pick < 22)
			op = CMD_SET_RGB;
		else if (pick < 40)
			op = CMD_SET_LVL;
		else if (pick < 48)
			op = CMD_SET_ALL;
		else if (pick < 56)
			op = CMD_FADE_OUT;
		else if (pick < 64)
			op = CMD_FADE_IN;
		else if (pick < 80)
			op = CMD_READ;
		else if (pick < 96)
			op = CMD_BLEND;
		else
			op = CMD_SPARE;
		if ($urandom_range(3) == 0)
			lvl = 8'($urandom);
		else
			lvl = 8'($urandom_range(100));
		send_cmd(op, 4'($urandom_range(15)), rand_chan(), rand_chan(), rand_chan(),
			lvl, 8'($urandom));
	endtask

	initial begin
		int ph;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Power-on reads and a blend at the corners
		send_cmd(CMD_READ, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_READ, 4'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_BLEND, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF);
		// Channel clamps: most negative, most positive, just above range, minus one
		send_cmd(CMD_SET_RGB, 4'd0, 8'h80, 8'h7F, 8'd63, 8'd0, 8'd0);
		send_cmd(CMD_SET_RGB, 4'd15, 8'h40, 8'd0, 8'hFF, 8'd0, 8'd0);
		send_cmd(CMD_SET_RGB, 4'd7, 8'd63, 8'd62, 8'd1, 8'd0, 8'd0);
		// Level clamps and edges
		send_cmd(CMD_SET_LVL, 4'd3, 8'd0, 8'd0, 8'd0, 8'h80, 8'd0);
		send_cmd(CMD_SET_LVL, 4'd5, 8'd0, 8'd0, 8'd0, 8'h7F, 8'd0);
		send_cmd(CMD_SET_LVL, 4'd9, 8'd0, 8'd0, 8'd0, 8'd101, 8'd0);
		send_cmd(CMD_SET_LVL, 4'd12, 8'd0, 8'd0, 8'd0, 8'd100, 8'd0);
		send_cmd(CMD_SET_LVL, 4'd15, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0);
		send_cmd(CMD_SET_ALL, 4'd0, 8'd0, 8'd0, 8'd0, 8'd37, 8'd0);
		send_cmd(CMD_BLEND, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h5A);
		send_cmd(CMD_BLEND, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
		// Fade in while not faded, then a double fade out
		send_cmd(CMD_FADE_IN, 4'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_FADE_OUT, 4'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_FADE_OUT, 4'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		// Writes while faded land in the saved levels and the stored colors
		send_cmd(CMD_SET_LVL, 4'd2, 8'd0, 8'd0, 8'd0, 8'd55, 8'd0);
		send_cmd(CMD_SET_RGB, 4'd4, 8'd50, 8'hC0, 8'd20, 8'd0, 8'd0);
		send_cmd(CMD_READ, 4'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_BLEND, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h4F);
		send_cmd(CMD_SET_ALL, 4'd0, 8'd0, 8'd0, 8'd0, 8'h9C, 8'd0);
		send_cmd(CMD_SET_ALL, 4'd0, 8'd0, 8'd0, 8'd0, 8'd80, 8'd0);
		// Restore, repeat restore, spare code, all levels to zero
		send_cmd(CMD_FADE_IN, 4'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_FADE_IN, 4'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_SPARE, 4'd11, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(CMD_SET_ALL, 4'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 8'd0);

		// Random phases: slow receiver, slow sender, then full rate
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 400; n++) begin
				send_random();
				// Drain every outstanding result once before going on
				if (ph == 1 && n == 199) begin
					s_axis_tvalid <= 1'b0;
					do
						@(posedge clk);
					while (reports_due != 0);
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (reports_due != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && reports_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
